// ===== rtl/core/atm_pkg.sv =====
// Shared types and constants for the alarm table matcher.
// Depends on nothing; atm_ctrl, the top level and the testbench import it.
`timescale 1ns / 1ps

package atm_pkg;

   // Field widths of one request and one response beat.
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int COLOUR_W = 3;
   localparam int STATUS_W = 3;

   // One stored entry is packed as {hour, minute, colour}.
   localparam int ENTRY_W = HOUR_W + MINUTE_W + COLOUR_W;

   // Request kinds.
   typedef enum logic [0:0] {
      REQ_ADD   = 1'b0,
      REQ_CHECK = 1'b1
   } req_kind_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_SAVED     = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_FIRES     = 3'd3,
      ST_NONE      = 3'd4
   } status_type;

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   // Result handed from the sequencer to the response register.
   typedef struct packed {
      logic                valid;
      status_type          status;
      logic [COLOUR_W-1:0] colour;
   } result_type;

endpackage

// ===== rtl/core/atm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module atm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/atm_ctrl.sv =====
// Sequencer of the alarm table: walks the stored entries through one comparator,
// then appends or reports. Depends on atm_pkg and atm_ram.
`timescale 1ns / 1ps

module atm_ctrl #(
   parameter int MAX_ENTRIES = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            req_type,
   input  logic [atm_pkg::HOUR_W-1:0]      req_hour,
   input  logic [atm_pkg::MINUTE_W-1:0]    req_minute,
   input  logic [atm_pkg::SECOND_W-1:0]    req_second,
   input  logic [atm_pkg::COLOUR_W-1:0]    req_colour,
   output logic                            busy,
   output atm_pkg::result_type             result
);

   import atm_pkg::*;

   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic                 found_ff, found_in;
   logic [COLOUR_W-1:0]  found_colour_ff, found_colour_in;

   // Latched request beat.
   logic                 kind_ff;
   logic [HOUR_W-1:0]    hour_ff;
   logic [MINUTE_W-1:0]  minute_ff;
   logic [SECOND_W-1:0]  second_ff;
   logic [COLOUR_W-1:0]  colour_ff;

   logic                 accept;
   logic                 rd_en;
   logic                 wr_en;
   logic [ENTRY_W-1:0]   rd_data;
   logic [HOUR_W-1:0]    rd_hour;
   logic [MINUTE_W-1:0]  rd_minute;
   logic [COLOUR_W-1:0]  rd_colour;
   logic                 hit;
   result_type           result_in;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // Entry storage.
   atm_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({hour_ff, minute_ff, colour_ff}),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign {rd_hour, rd_minute, rd_colour} = rd_data;

   // The shared comparator: one entry a cycle, compared in the cycle after its read.
   assign hit = pend_ff && (rd_hour == hour_ff) && (rd_minute == minute_ff);

   // Next-state logic of the sequencer.
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      issue_in        = issue_ff;
      pend_in         = 1'b0;
      found_in        = found_ff;
      found_colour_in = found_colour_ff;
      rd_en           = 1'b0;
      wr_en           = 1'b0;
      result_in       = '{valid: 1'b0, status: ST_NONE, colour: '0};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               issue_in = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_en    = (issue_ff < count_ff);
            pend_in  = rd_en;
            issue_in = issue_ff + CNT_W'(rd_en);
            if (hit) begin
               found_in        = 1'b1;
               found_colour_in = rd_colour;
               state_in        = S_FINISH;
            end else if (!rd_en) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            result_in.valid = 1'b1;
            if (kind_ff == REQ_ADD) begin
               if (found_ff) begin
                  result_in.status = ST_DUPLICATE;
               end else if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                  result_in.status = ST_FULL;
               end else begin
                  result_in.status = ST_SAVED;
                  wr_en            = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
               end
            end else begin
               if (found_ff && (second_ff == '0)) begin
                  result_in.status = ST_FIRES;
                  result_in.colour = found_colour_ff;
               end
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      issue_ff        <= issue_in;
      found_colour_ff <= found_colour_in;
      if (accept) begin
         kind_ff   <= req_type;
         hour_ff   <= req_hour;
         minute_ff <= req_minute;
         second_ff <= req_second;
         colour_ff <= req_colour;
      end
   end

   assign result = result_in;

endmodule

// ===== rtl/core/alarm_table_matcher.sv =====
// Top level of the alarm table matcher: sequencer and response register.
// Depends on atm_pkg and atm_ctrl.
`timescale 1ns / 1ps
//
//  Channel    Handshake            Payload
//  --------   ------------------   -----------------------------------------------
//  request    start, busy          req_type, req_hour, req_minute, req_second,
//                                   req_colour
//  response   rsp_strobe           rsp_status, rsp_fired_colour
//
//  A beat is taken when start is high and busy is low; busy then stays high.
//  The one comparator walks the entry RAM one read per cycle, then the sequencer
//  finishes and the response register strobes; a match ends the walk early.
//  rsp_strobe is high for a single cycle; the receiver cannot stall.
//  Synchronous reset empties the table; entry contents are not cleared.

module alarm_table_matcher #(
   parameter int MAX_ENTRIES = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [atm_pkg::HOUR_W-1:0]    req_hour,
   input  logic [atm_pkg::MINUTE_W-1:0]  req_minute,
   input  logic [atm_pkg::SECOND_W-1:0]  req_second,
   input  logic [atm_pkg::COLOUR_W-1:0]  req_colour,
   output logic                          rsp_strobe,
   output logic [atm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [atm_pkg::COLOUR_W-1:0]  rsp_fired_colour
);

   import atm_pkg::*;

   result_type          result;
   logic                rsp_strobe_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COLOUR_W-1:0] rsp_colour_ff;

   atm_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .req_hour   (req_hour),
      .req_minute (req_minute),
      .req_second (req_second),
      .req_colour (req_colour),
      .busy       (busy),
      .result     (result)
   );

   // Response register: one beat per finished request.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_status_ff <= result.status;
         rsp_colour_ff <= result.colour;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_fired_colour = rsp_colour_ff;

   // An accepted request keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted request");

   // A response only follows a cycle in which a request was in progress.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response strobe without a request in progress");

   // Only a firing alarm reports a colour.
   a_colour_only_fires: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_FIRES)) |-> (rsp_fired_colour == '0))
      else $error("colour reported on a non-firing response");

   // The status code is one of the defined codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == ST_SAVED || rsp_status == ST_DUPLICATE ||
                      rsp_status == ST_FULL  || rsp_status == ST_FIRES ||
                      rsp_status == ST_NONE))
      else $error("undefined status code on a response");

endmodule

// ===== tb/sv/alarm_table_matcher_tb.sv =====
// Self-checking testbench for the alarm table matcher: predicts each response
// from a shadow copy of the alarm table and checks every strobed response beat.
// Depends on atm_pkg and the alarm_table_matcher RTL.
`timescale 1ns / 1ps

module alarm_table_matcher_tb;
   import atm_pkg::*;

   localparam int TABLE_DEPTH = 10;
   localparam int PHASE_ITEMS = 234;

   // One predicted response beat.
   typedef struct {
      status_type          status;
      logic [COLOUR_W-1:0] colour;
   } alarm_response_type;

   // Shadow alarm table plus the queue of responses still owed by the block.
   class alarm_scoreboard;
      logic [HOUR_W-1:0]   slot_hour[TABLE_DEPTH];
      logic [MINUTE_W-1:0] slot_minute[TABLE_DEPTH];
      logic [COLOUR_W-1:0] slot_colour[TABLE_DEPTH];
      int unsigned         slot_count;
      alarm_response_type  owed_responses[$];
      int unsigned         mismatch_count;
      int unsigned         request_count;
      int unsigned         status_seen[5];

      function new();
         slot_count = 0;
         mismatch_count = 0;
         request_count = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // Print one line per mismatch and keep a tally.
      function void report_mismatch(string what);
         mismatch_count++;
         $display("[%0t] mismatch: %s", $time, what);
      endfunction

      // Work out the response to an accepted request and update the shadow table.
      function void note_request(req_kind_type kind, logic [HOUR_W-1:0] hour,
                                 logic [MINUTE_W-1:0] minute,
                                 logic [SECOND_W-1:0] second,
                                 logic [COLOUR_W-1:0] colour);
         alarm_response_type resp;
         int                 hit;
         hit = -1;
         for (int i = 0; i < slot_count; i++) begin
            if (hit < 0 && slot_hour[i] == hour && slot_minute[i] == minute) hit = i;
         end
         resp.colour = '0;
         if (kind == REQ_ADD) begin
            if (hit >= 0) begin
               resp.status = ST_DUPLICATE;
            end else if (slot_count >= TABLE_DEPTH) begin
               resp.status = ST_FULL;
            end else begin
               slot_hour[slot_count] = hour;
               slot_minute[slot_count] = minute;
               slot_colour[slot_count] = colour;
               slot_count++;
               resp.status = ST_SAVED;
            end
         end else begin
            // Stored alarms carry second zero, so only second zero can match.
            if (second == '0 && hit >= 0) begin
               resp.status = ST_FIRES;
               resp.colour = slot_colour[hit];
            end else begin
               resp.status = ST_NONE;
            end
         end
         request_count++;
         status_seen[resp.status]++;
         owed_responses.push_back(resp);
      endfunction

      // Compare a strobed response beat with the oldest owed response.
      function void check_response(logic [STATUS_W-1:0] status,
                                   logic [COLOUR_W-1:0] colour);
         alarm_response_type want;
         if (owed_responses.size() == 0) begin
            report_mismatch($sformatf("unexpected response status=%0d colour=%0d",
                                      status, colour));
            return;
         end
         want = owed_responses.pop_front();
         if (status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
         if (colour !== want.colour)
            report_mismatch($sformatf("fired colour %0d, predicted %0d", colour,
                                      want.colour));
      endfunction

      function int unsigned pending();
         return owed_responses.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_type;
   logic [HOUR_W-1:0]   req_hour;
   logic [MINUTE_W-1:0] req_minute;
   logic [SECOND_W-1:0] req_second;
   logic [COLOUR_W-1:0] req_colour;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [COLOUR_W-1:0] rsp_fired_colour;

   alarm_scoreboard alarm_sb;

   alarm_table_matcher #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_hour         (req_hour),
      .req_minute       (req_minute),
      .req_second       (req_second),
      .req_colour       (req_colour),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_fired_colour (rsp_fired_colour)
   );

   // Free-running 10 ns clock.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Response monitor: a strobed beat is taken at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) alarm_sb.check_response(rsp_status, rsp_fired_colour);
   end

   // Present one request beat, after a random idle stretch, and wait for it to be taken.
   task automatic send_beat(input req_kind_type kind, input logic [HOUR_W-1:0] hour,
                            input logic [MINUTE_W-1:0] minute,
                            input logic [SECOND_W-1:0] second,
                            input logic [COLOUR_W-1:0] colour, input int idle_pct);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_type   <= kind;
      req_hour   <= hour;
      req_minute <= minute;
      req_second <= second;
      req_colour <= colour;
      do @(posedge clock); while (busy !== 1'b0);
      alarm_sb.note_request(kind, hour, minute, second, colour);
   endtask

   // Random requests: time checks aimed mostly at stored alarms, adds that
   // repeat a stored alarm half of the time, and some plain noise.
   task automatic run_random_phase(input int items, input int idle_pct);
      int                  roll;
      int                  pick;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic [COLOUR_W-1:0] colour;
      for (int n = 0; n < items; n++) begin
         roll   = int'($urandom_range(99));
         hour   = HOUR_W'($urandom_range(31));
         minute = MINUTE_W'($urandom_range(63));
         second = SECOND_W'($urandom_range(63));
         colour = COLOUR_W'($urandom_range(7));
         if (alarm_sb.slot_count > 0 && (roll < 15 || (roll >= 30 && roll < 75))) begin
            pick   = int'($urandom_range(alarm_sb.slot_count - 1));
            hour   = alarm_sb.slot_hour[pick];
            minute = alarm_sb.slot_minute[pick];
            if ($urandom_range(1) != 0) second = '0;
         end
         send_beat((roll < 30) ? REQ_ADD : REQ_CHECK, hour, minute, second,
                   colour, idle_pct);
      end
   endtask

   // Global limit on the run.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      alarm_sb   = new();
      reset      = 1'b1;
      start      = 1'b0;
      req_type   = REQ_ADD;
      req_hour   = '0;
      req_minute = '0;
      req_second = '0;
      req_colour = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes, ignored fields, duplicates, a full table.
      send_beat(REQ_CHECK, 5'd0,  6'd0,  6'd0,  3'd0, 14);
      send_beat(REQ_ADD,   5'd23, 6'd59, 6'd0,  3'd4, 14);
      send_beat(REQ_ADD,   5'd0,  6'd0,  6'd63, 3'd0, 14);
      send_beat(REQ_CHECK, 5'd23, 6'd59, 6'd0,  3'd7, 14);
      send_beat(REQ_CHECK, 5'd23, 6'd59, 6'd1,  3'd0, 14);
      send_beat(REQ_CHECK, 5'd0,  6'd0,  6'd0,  3'd0, 14);
      send_beat(REQ_CHECK, 5'd0,  6'd0,  6'd59, 3'd0, 14);
      send_beat(REQ_ADD,   5'd23, 6'd59, 6'd0,  3'd2, 14);
      // Out-of-range hour, minute and colour are stored as raw bits.
      send_beat(REQ_ADD,   5'd31, 6'd63, 6'd0,  3'd7, 14);
      send_beat(REQ_CHECK, 5'd31, 6'd63, 6'd0,  3'd0, 14);
      send_beat(REQ_CHECK, 5'd31, 6'd63, 6'd63, 3'd0, 14);
      send_beat(REQ_ADD,   5'd5,  6'd0,  6'd42, 3'd5, 14);
      send_beat(REQ_CHECK, 5'd0,  6'd59, 6'd0,  3'd0, 14);
      // Fill the remaining slots.
      send_beat(REQ_ADD,   5'd1,  6'd1,  6'd21, 3'd1, 14);
      send_beat(REQ_ADD,   5'd2,  6'd2,  6'd0,  3'd2, 14);
      send_beat(REQ_ADD,   5'd3,  6'd3,  6'd7,  3'd3, 14);
      send_beat(REQ_ADD,   5'd4,  6'd4,  6'd0,  3'd6, 14);
      send_beat(REQ_ADD,   5'd6,  6'd6,  6'd30, 3'd7, 14);
      send_beat(REQ_ADD,   5'd7,  6'd7,  6'd0,  3'd3, 14);
      // Full table, then a duplicate while full, then the last slot firing.
      send_beat(REQ_ADD,   5'd12, 6'd34, 6'd0,  3'd1, 14);
      send_beat(REQ_ADD,   5'd1,  6'd1,  6'd0,  3'd4, 14);
      send_beat(REQ_CHECK, 5'd7,  6'd7,  6'd0,  3'd0, 14);
      send_beat(REQ_CHECK, 5'd12, 6'd34, 6'd0,  3'd0, 14);
      send_beat(REQ_CHECK, 5'd7,  6'd7,  6'd30, 3'd0, 14);

      // Random traffic with the sender idling rarely, often, then never.
      run_random_phase(PHASE_ITEMS, 14);
      run_random_phase(PHASE_ITEMS, 60);
      run_random_phase(PHASE_ITEMS, 0);
      start <= 1'b0;

      // Drain, then allow a full-table walk for any stray beat.
      while (alarm_sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d requests: %0d saved, %0d duplicate, %0d full,",
               alarm_sb.request_count, alarm_sb.status_seen[ST_SAVED],
               alarm_sb.status_seen[ST_DUPLICATE], alarm_sb.status_seen[ST_FULL]);
      $display("%0d alarms fired, %0d checks without alarm; %0d mismatches.",
               alarm_sb.status_seen[ST_FIRES], alarm_sb.status_seen[ST_NONE],
               alarm_sb.mismatch_count);
      if (alarm_sb.mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/atm_pkg.sv
rtl/core/atm_ram.sv
rtl/core/atm_ctrl.sv
rtl/core/alarm_table_matcher.sv
tb/sv/alarm_table_matcher_tb.sv
